// ----- design/fem_element_curl_pressure_assembly_unit_macros.svh -----
// Assertion helpers for the top-level file, which checks itself.
`ifndef FEM_ELEMENT_CURL_PRESSURE_ASSEMBLY_UNIT_MACROS_SVH
`define FEM_ELEMENT_CURL_PRESSURE_ASSEMBLY_UNIT_MACROS_SVH

`define FECP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FECP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fecp_pkg.sv -----
package fecp_pkg;

  localparam int unsigned MaxShapeP = 8;
  localparam int unsigned MaxShapeV = 8;
  localparam int unsigned MaxNodes  = 16;
  localparam int unsigned DofBits   = 20;
  localparam int unsigned NodeW     = 4;
  localparam int unsigned DofW      = 3;
  localparam int unsigned ShapeAw   = DofW + NodeW;
  localparam int unsigned ShapeDepth = MaxShapeP * MaxNodes;

  localparam logic [2:0] ReqNode   = 3'd0;
  localparam logic [2:0] ReqScalar = 3'd1;
  localparam logic [2:0] ReqCurl   = 3'd2;
  localparam logic [2:0] ReqSConn  = 3'd3;
  localparam logic [2:0] ReqVConn  = 3'd4;
  localparam logic [2:0] ReqComp   = 3'd5;

  // Controller to datapath.
  typedef struct packed {
    logic             node_wr;
    logic             sconn_wr;
    logic             vconn_wr;
    logic             mul_a;      // unused; stage 1 of a node data product runs on node_wr
    logic             mul_b;      // stage 2 of a node data product
    logic             rd;         // fetch operands for (i, j, k)
    logic             mac_u;      // u = factor * shape
    logic             mac_t;      // acc += u * curl
    logic             clr;        // clear accumulator
    logic             emit;       // load output register
    logic             last;
    logic [DofW-1:0]  i;
    logic [DofW-1:0]  j;
    logic [NodeW-1:0] k;
  } ctrl_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  // Floor shift by 16 then saturate to signed 32 bits.
  function automatic logic signed [31:0] sat32_shr16(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = p[63:16];
    if (s > 48'sd2147483647) return 32'sh7fffffff;
    if (s < -48'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

endpackage

// ----- design/fem_element_curl_pressure_assembly_unit.sv -----
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid_i/in_stall_o | one load or compute request
// out     | output    | out_valid_o/out_stall_i | one triplet (row, col, value, last)
//
// Node data passes through the NodeB state, since its two products are registered.
// A compute request runs count_p*count_v pairs (counts after saturation) through the one
// multiply-accumulate pipe, which walks the nodes of each pair.
// Reset is asynchronous and active low; stored element data is undefined until loaded.
// The block takes no request while a compute runs; an output stall holds the walk.
`include "fem_element_curl_pressure_assembly_unit_macros.svh"
module fem_element_curl_pressure_assembly_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [3:0]         node_index_i,
  input  logic [2:0]         dof_index_i,
  input  logic signed [31:0] jacobian_det_i,
  input  logic signed [31:0] quad_weight_i,
  input  logic signed [31:0] coeff_value_i,
  input  logic signed [31:0] shape_value_i,
  input  logic [20:0]        global_dof_i,
  input  logic [3:0]         count_p_i,
  input  logic [3:0]         count_v_i,
  input  logic [4:0]         count_nodes_i,
  input  logic               area_positive_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [19:0]        row_index_o,
  output logic [19:0]        col_index_o,
  output logic signed [47:0] entry_value_o,
  output logic               last_entry_o
);
  fecp_pkg::ctrl_t ctrl;
  fecp_pkg::stat_t stat;
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  fecp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .count_p_i, .count_v_i,
    .count_nodes_i, .area_positive_i, .stat_i(stat), .ctrl_o(ctrl));

  fecp_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .shp_wr_i(acc && req_type_i == fecp_pkg::ReqScalar),
    .curl_wr_i(acc && req_type_i == fecp_pkg::ReqCurl),
    .node_index_i, .dof_index_i, .jacobian_det_i, .quad_weight_i, .coeff_value_i,
    .shape_value_i, .global_dof_i, .out_stall_i, .stat_o(stat), .out_valid_o,
    .row_index_o, .col_index_o, .entry_value_o, .last_entry_o);

  `FECP_ASSERT_IMPL(a_no_emit_busy, clk_i, rst_ni, ctrl.emit, !stat.out_busy,
    "triplet loaded while output held")
  `FECP_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, ctrl.emit, out_valid_o,
    "loaded triplet not shown")
  `FECP_ASSERT_IMPL(a_no_clr_mac, clk_i, rst_ni, ctrl.clr, !ctrl.mac_t,
    "accumulator cleared while terms in flight")
endmodule

// ----- design/fecp_ram.sv -----
module fecp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] wa_i,
  input  logic [Width-1:0]         wd_i,
  input  logic [$clog2(Depth)-1:0] ra_i,
  output logic [Width-1:0]         rd_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[wa_i] <= wd_i;
    rd_o <= mem_q[ra_i];
  end
endmodule

// ----- design/fecp_datapath.sv -----
module fecp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fecp_pkg::ctrl_t     ctrl_i,
  input  logic                shp_wr_i,
  input  logic                curl_wr_i,
  input  logic [3:0]          node_index_i,
  input  logic [2:0]          dof_index_i,
  input  logic signed [31:0]  jacobian_det_i,
  input  logic signed [31:0]  quad_weight_i,
  input  logic signed [31:0]  coeff_value_i,
  input  logic signed [31:0]  shape_value_i,
  input  logic [20:0]         global_dof_i,
  input  logic                out_stall_i,
  output fecp_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  output logic [19:0]         row_index_o,
  output logic [19:0]         col_index_o,
  output logic signed [47:0]  entry_value_o,
  output logic                last_entry_o
);
  logic signed [31:0] factor_q [fecp_pkg::MaxNodes];
  logic               counts_q [fecp_pkg::MaxNodes];
  logic [19:0]        sconn_q [fecp_pkg::MaxShapeP];
  logic [19:0]        vconn_q [fecp_pkg::MaxShapeV];
  logic signed [31:0] t_q, c_q, shp_rd, curl_rd, fac_q, u_q, curl_q;
  logic               cnt_q, cnt_u_q;
  logic [3:0]         nidx_q;
  logic               wpos_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] term;
  logic signed [47:0] sat48;
  logic valid_q;

  fecp_ram #(.Width(32), .Depth(fecp_pkg::ShapeDepth)) u_shp (
    .clk_i, .we_i(shp_wr_i), .wa_i({dof_index_i, node_index_i}), .wd_i(shape_value_i),
    .ra_i({ctrl_i.i, ctrl_i.k}), .rd_o(shp_rd));
  fecp_ram #(.Width(32), .Depth(fecp_pkg::ShapeDepth)) u_curl (
    .clk_i, .we_i(curl_wr_i), .wa_i({dof_index_i, node_index_i}), .wd_i(shape_value_i),
    .ra_i({ctrl_i.j, ctrl_i.k}), .rd_o(curl_rd));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.node_wr) begin
      t_q    <= fecp_pkg::sat32_shr16(64'(jacobian_det_i) * 64'(quad_weight_i));
      c_q    <= coeff_value_i;
      nidx_q <= node_index_i;
      wpos_q <= quad_weight_i > 32'sd0;
    end
    if (ctrl_i.mul_b) begin
      factor_q[nidx_q] <= fecp_pkg::sat32_shr16(64'(t_q) * 64'(c_q));
      counts_q[nidx_q] <= wpos_q;
    end
    if (ctrl_i.sconn_wr) sconn_q[dof_index_i] <= 20'(global_dof_i - 21'd1);
    if (ctrl_i.vconn_wr) vconn_q[dof_index_i] <= 20'(global_dof_i - 21'd1);
    if (ctrl_i.rd) begin
      fac_q <= factor_q[ctrl_i.k];
      cnt_q <= counts_q[ctrl_i.k];
    end
    // The curl value is held beside u, since the memory already reads the next node.
    if (ctrl_i.mac_u) begin
      u_q     <= fecp_pkg::sat32_shr16(64'(fac_q) * 64'(shp_rd));
      curl_q  <= curl_rd;
      cnt_u_q <= cnt_q;
    end
  end

  assign term = 64'(64'(u_q) * 64'(curl_q)) >>> 16;
  always_comb begin
    if (acc_q > 64'sd140737488355327) sat48 = 48'sh7fffffffffff;
    else if (acc_q < -64'sd140737488355328) sat48 = 48'sh800000000000;
    else sat48 = acc_q[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      if (ctrl_i.clr) acc_q <= '0;
      else if (ctrl_i.mac_t && cnt_u_q) acc_q <= acc_q + term;
      if (ctrl_i.emit) valid_q <= 1'b1;
      else if (!out_stall_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      row_index_o   <= sconn_q[ctrl_i.i];
      col_index_o   <= vconn_q[ctrl_i.j];
      entry_value_o <= sat48;
      last_entry_o  <= ctrl_i.last;
    end
  end

  assign out_valid_o     = valid_q;
  assign stat_o.out_busy = valid_q && out_stall_i;
endmodule

// ----- design/fecp_ctrl.sv -----
module fecp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      req_type_i,
  input  logic [3:0]      count_p_i,
  input  logic [3:0]      count_v_i,
  input  logic [4:0]      count_nodes_i,
  input  logic            area_positive_i,
  input  fecp_pkg::stat_t stat_i,
  output fecp_pkg::ctrl_t ctrl_o
);
  typedef enum logic [2:0] {Idle, NodeB, Fetch, Mac, Drain, Emit} state_e;
  state_e state_q;
  logic [3:0] np_q, nv_q;
  logic [4:0] nn_q;
  logic [2:0] i_q, j_q;
  logic [3:0] k_q;
  logic [4:0] issued_q;
  logic p1_q, p2_q;
  logic acc;

  logic [3:0] np, nv;
  logic [4:0] nn;
  assign np = (count_p_i > 4'(fecp_pkg::MaxShapeP)) ? 4'(fecp_pkg::MaxShapeP) : count_p_i;
  assign nv = (count_v_i > 4'(fecp_pkg::MaxShapeV)) ? 4'(fecp_pkg::MaxShapeV) : count_v_i;
  assign nn = (count_nodes_i > 5'(fecp_pkg::MaxNodes)) ? 5'(fecp_pkg::MaxNodes)
                                                       : count_nodes_i;

  assign in_stall_o = state_q != Idle;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.i = i_q;
    ctrl_o.j = j_q;
    ctrl_o.k = k_q;
    ctrl_o.node_wr  = acc && req_type_i == fecp_pkg::ReqNode;
    ctrl_o.sconn_wr = acc && req_type_i == fecp_pkg::ReqSConn;
    ctrl_o.vconn_wr = acc && req_type_i == fecp_pkg::ReqVConn;
    ctrl_o.mul_b    = state_q == NodeB;
    ctrl_o.rd       = state_q == Mac && issued_q < nn_q;
    ctrl_o.mac_u    = p1_q;
    ctrl_o.mac_t    = p2_q;
    ctrl_o.clr      = state_q == Fetch;
    ctrl_o.emit     = state_q == Emit && !stat_i.out_busy;
    ctrl_o.last     = (4'(i_q) + 4'd1 == np_q) && (4'(j_q) + 4'd1 == nv_q);
  end

  // Operands are registered from the node array and memories, then pass two
  // product stages (mac_u into u_q, mac_t into the accumulator) behind the fetch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      np_q <= '0; nv_q <= '0; nn_q <= '0;
      i_q <= '0; j_q <= '0; k_q <= '0; issued_q <= '0;
      p1_q <= 1'b0; p2_q <= 1'b0;
    end else begin
      p1_q <= ctrl_o.rd;
      p2_q <= p1_q;
      unique case (state_q)
        Idle: begin
          if (acc && req_type_i == fecp_pkg::ReqNode) state_q <= NodeB;
          if (acc && req_type_i == fecp_pkg::ReqComp && area_positive_i &&
              np != 4'd0 && nv != 4'd0) begin
            np_q <= np; nv_q <= nv; nn_q <= nn;
            i_q <= '0; j_q <= '0;
            state_q <= Fetch;
          end
        end
        NodeB: state_q <= Idle;
        Fetch: begin
          k_q <= '0;
          issued_q <= '0;
          state_q <= Mac;
        end
        Mac: begin
          if (issued_q < nn_q) begin
            issued_q <= issued_q + 5'd1;
            k_q <= k_q + 4'd1;
          end else begin
            state_q <= Drain;
          end
        end
        Drain: if (!p1_q && !p2_q) state_q <= Emit;
        Emit: begin
          if (!stat_i.out_busy) begin
            if (ctrl_o.last) state_q <= Idle;
            else begin
              state_q <= Fetch;
              if (4'(j_q) + 4'd1 == nv_q) begin
                j_q <= '0;
                i_q <= i_q + 3'd1;
              end else j_q <= j_q + 3'd1;
            end
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end
endmodule
